// ===== rtl/srp_pkg.sv =====
`default_nettype none

package srp_pkg;

  localparam logic [7:0] CHAR_LF = 8'h0A;
  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_S  = 8'h53;
  localparam logic [7:0] CHAR_0  = 8'h30;
  localparam logic [7:0] CHAR_9  = 8'h39;
  localparam logic [7:0] CHAR_UA = 8'h41;
  localparam logic [7:0] CHAR_UF = 8'h46;
  localparam logic [7:0] CHAR_LA = 8'h61;
  localparam logic [7:0] CHAR_LF_HEX = 8'h66;

  localparam logic [3:0] KIND_S0      = 4'd0;
  localparam logic [3:0] KIND_S1      = 4'd1;
  localparam logic [3:0] KIND_S2      = 4'd2;
  localparam logic [3:0] KIND_S3      = 4'd3;
  localparam logic [3:0] KIND_S6      = 4'd6;
  localparam logic [3:0] KIND_S7      = 4'd7;
  localparam logic [3:0] KIND_S8      = 4'd8;
  localparam logic [3:0] KIND_UNKNOWN = 4'd10;

  localparam logic ITEM_WRITE = 1'b0;
  localparam logic ITEM_END   = 1'b1;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_BAD_HEX = 2'd1;
  localparam logic [1:0] STATUS_SHORT   = 2'd2;

  typedef struct packed {
    logic        item_kind;
    logic [3:0]  record_kind;
    logic [31:0] address;
    logic [7:0]  data_byte;
    logic [7:0]  checksum_byte;
    logic [1:0]  status;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } result_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] nib;
  } hex_t;

  function automatic hex_t hex_value(input logic [7:0] c);
    hex_t       r;
    logic [7:0] d;
    r.ok  = 1'b1;
    r.nib = 4'd0;
    d     = 8'd0;
    if (c >= CHAR_0 && c <= CHAR_9) begin
      d = c - CHAR_0;
    end else if (c >= CHAR_UA && c <= CHAR_UF) begin
      d = c - CHAR_UA + 8'd10;
    end else if (c >= CHAR_LA && c <= CHAR_LF_HEX) begin
      d = c - CHAR_LA + 8'd10;
    end else begin
      r.ok = 1'b0;
    end
    r.nib = d[3:0];
    return r;
  endfunction

  function automatic logic [2:0] address_bytes(input logic [3:0] kind);
    logic [2:0] n;
    n = 3'd2;
    if (kind == KIND_S2 || kind == KIND_S6 || kind == KIND_S8) begin
      n = 3'd3;
    end else if (kind == KIND_S3 || kind == KIND_S7) begin
      n = 3'd4;
    end
    return n;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/srp_char_if.sv =====
`default_nettype none

interface srp_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink (input valid, input char_code, output ready);
endinterface

`default_nettype wire

// ===== rtl/srp_item_if.sv =====
`default_nettype none

interface srp_item_if;
  logic        valid;
  logic        ready;
  logic        item_kind;
  logic [3:0]  record_kind;
  logic [31:0] address;
  logic [7:0]  data_byte;
  logic [7:0]  checksum_byte;
  logic [1:0]  status;

  modport source (output valid, output item_kind, output record_kind, output address,
                  output data_byte, output checksum_byte, output status, input ready);
  modport sink (input valid, input item_kind, input record_kind, input address,
                input data_byte, input checksum_byte, input status, output ready);
endinterface

`default_nettype wire

// ===== rtl/srp_parse_core.sv =====
`default_nettype none

module srp_parse_core (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             fire,
  input  wire logic [7:0]       char_code,
  output srp_pkg::result_t      result
);

  typedef enum logic [2:0] {
    PH_START,
    PH_TYPE,
    PH_COUNT,
    PH_ADDR,
    PH_DATA,
    PH_CSUM,
    PH_DONE
  } phase_t;

  phase_t        phase, phase_next;
  logic [3:0]    type_code, type_code_next;
  logic [7:0]    bytes_left, bytes_left_next;
  logic [31:0]   address_accum, address_accum_next;
  logic [31:0]   start_address, start_address_next;
  logic [3:0]    high_nibble, high_nibble_next;
  logic          nibble_phase, nibble_phase_next;
  logic          bad_hex, bad_hex_next;
  logic [2:0]    addr_left, addr_left_next;
  logic [7:0]    checksum_hold, checksum_hold_next;

  srp_pkg::hex_t hx;
  logic [7:0]    byte_val;
  logic [7:0]    bl_dec;
  logic [2:0]    al_dec;
  logic [31:0]   accum_shift;

  assign hx          = srp_pkg::hex_value(char_code);
  assign byte_val    = {high_nibble, hx.nib};
  assign bl_dec      = (bytes_left != 8'd0) ? bytes_left - 8'd1 : 8'd0;
  assign al_dec      = (addr_left != 3'd0) ? addr_left - 3'd1 : 3'd0;
  assign accum_shift = {address_accum[23:0], byte_val};

  always_comb begin
    phase_next         = phase;
    type_code_next     = type_code;
    bytes_left_next    = bytes_left;
    address_accum_next = address_accum;
    start_address_next = start_address;
    high_nibble_next   = high_nibble;
    nibble_phase_next  = nibble_phase;
    bad_hex_next       = bad_hex;
    addr_left_next     = addr_left;
    checksum_hold_next = checksum_hold;
    result             = '0;

    if (!fire || char_code == srp_pkg::CHAR_CR) begin
      result.valid = 1'b0;
    end else if (char_code == srp_pkg::CHAR_LF) begin
      if (phase != PH_START) begin
        result.valid            = 1'b1;
        result.item.item_kind   = srp_pkg::ITEM_END;
        result.item.record_kind = (phase == PH_TYPE) ? srp_pkg::KIND_UNKNOWN : type_code;
        result.item.address     = start_address;
        result.item.checksum_byte = (phase == PH_DONE) ? checksum_hold : 8'd0;
        priority if (bad_hex) begin
          result.item.status = srp_pkg::STATUS_BAD_HEX;
        end else if (phase != PH_DONE) begin
          result.item.status = srp_pkg::STATUS_SHORT;
        end else begin
          result.item.status = srp_pkg::STATUS_OK;
        end
      end
      phase_next         = PH_START;
      type_code_next     = 4'd0;
      bytes_left_next    = 8'd0;
      address_accum_next = 32'd0;
      start_address_next = 32'd0;
      high_nibble_next   = 4'd0;
      nibble_phase_next  = 1'b0;
      bad_hex_next       = 1'b0;
      addr_left_next     = 3'd0;
      checksum_hold_next = 8'd0;
    end else begin
      unique case (phase)
        PH_START: begin
          type_code_next = (char_code == srp_pkg::CHAR_S) ? srp_pkg::KIND_S0
                                                           : srp_pkg::KIND_UNKNOWN;
          phase_next     = PH_TYPE;
        end
        PH_TYPE: begin
          if (type_code != srp_pkg::KIND_UNKNOWN &&
              char_code >= srp_pkg::CHAR_0 && char_code <= srp_pkg::CHAR_9) begin
            type_code_next = hx.nib;
          end else begin
            type_code_next = srp_pkg::KIND_UNKNOWN;
          end
          phase_next        = PH_COUNT;
          nibble_phase_next = 1'b0;
        end
        PH_COUNT, PH_ADDR, PH_DATA, PH_CSUM: begin
          if (!hx.ok) begin
            bad_hex_next = 1'b1;
          end
          if (!nibble_phase) begin
            high_nibble_next  = hx.nib;
            nibble_phase_next = 1'b1;
          end else begin
            nibble_phase_next = 1'b0;
            unique case (phase)
              PH_COUNT: begin
                bytes_left_next    = byte_val;
                addr_left_next     = srp_pkg::address_bytes(type_code);
                address_accum_next = 32'd0;
                phase_next         = PH_ADDR;
              end
              PH_ADDR: begin
                address_accum_next = accum_shift;
                bytes_left_next    = bl_dec;
                addr_left_next     = al_dec;
                if (al_dec == 3'd0) begin
                  start_address_next = accum_shift;
                  phase_next         = (bl_dec > 8'd1) ? PH_DATA : PH_CSUM;
                end
              end
              PH_DATA: begin
                if (type_code >= srp_pkg::KIND_S1 && type_code <= srp_pkg::KIND_S3) begin
                  result.valid            = 1'b1;
                  result.item.item_kind   = srp_pkg::ITEM_WRITE;
                  result.item.record_kind = type_code;
                  result.item.address     = address_accum;
                  result.item.data_byte   = byte_val;
                  result.item.status      = srp_pkg::STATUS_OK;
                end
                address_accum_next = address_accum + 32'd1;
                bytes_left_next    = bl_dec;
                if (bl_dec <= 8'd1) begin
                  phase_next = PH_CSUM;
                end
              end
              default: begin
                checksum_hold_next = byte_val;
                phase_next         = PH_DONE;
              end
            endcase
          end
        end
        default: begin
          phase_next = phase;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_START;
      type_code     <= 4'd0;
      bytes_left    <= 8'd0;
      address_accum <= 32'd0;
      start_address <= 32'd0;
      high_nibble   <= 4'd0;
      nibble_phase  <= 1'b0;
      bad_hex       <= 1'b0;
      addr_left     <= 3'd0;
      checksum_hold <= 8'd0;
    end else begin
      phase         <= phase_next;
      type_code     <= type_code_next;
      bytes_left    <= bytes_left_next;
      address_accum <= address_accum_next;
      start_address <= start_address_next;
      high_nibble   <= high_nibble_next;
      nibble_phase  <= nibble_phase_next;
      bad_hex       <= bad_hex_next;
      addr_left     <= addr_left_next;
      checksum_hold <= checksum_hold_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/srp_out_buffer.sv =====
`default_nettype none

module srp_out_buffer (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire srp_pkg::item_t  push_item,
  output logic                 full,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output srp_pkg::item_t       out_item
);

  srp_pkg::item_t slot [2];
  logic [1:0]     count;
  logic           pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count != 2'd0);
  assign full      = (count == 2'd2);
  assign out_item  = slot[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (count == 2'd2) begin
        slot[0] <= slot[1];
      end else if (push) begin
        slot[0] <= push_item;
      end
    end else if (push) begin
      if (count == 2'd0) begin
        slot[0] <= push_item;
      end else begin
        slot[1] <= push_item;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/srecord_line_parser.sv =====
`default_nettype none

// channel | dir | payload                                              | handshake
// chars   | in  | char_code                                            | valid/ready
// items   | out | item_kind record_kind address data_byte               | valid/ready
//         |     | checksum_byte status                                 |
//
// One character is taken every cycle while the output buffer is not full; a result
// passes from the input register through the parse logic into the output buffer.
// The parser state updates only when the held character advances (buffer not full).
// rst clears the input register, the parser state and the two-entry output buffer.
// While the output buffer is full the input register holds its character and
// chars.ready drops.

module srecord_line_parser (
  input  wire logic   clk,
  input  wire logic   rst,
  srp_char_if.sink    chars,
  srp_item_if.source  items
);

  logic             char_valid;
  logic [7:0]       char_hold;
  logic             advance;
  logic             full;
  srp_pkg::result_t result;
  srp_pkg::item_t   head;

  assign advance     = char_valid && !full;
  assign chars.ready = !char_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      char_valid <= 1'b0;
    end else if (chars.valid && chars.ready) begin
      char_valid <= 1'b1;
    end else if (advance) begin
      char_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (chars.valid && chars.ready) begin
      char_hold <= chars.char_code;
    end
  end

  srp_parse_core u_core (
    .clk       (clk),
    .rst       (rst),
    .fire      (advance),
    .char_code (char_hold),
    .result    (result)
  );

  srp_out_buffer u_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (result.valid),
    .push_item (result.item),
    .full      (full),
    .out_valid (items.valid),
    .out_ready (items.ready),
    .out_item  (head)
  );

  assign items.item_kind     = head.item_kind;
  assign items.record_kind   = head.record_kind;
  assign items.address       = head.address;
  assign items.data_byte     = head.data_byte;
  assign items.checksum_byte = head.checksum_byte;
  assign items.status        = head.status;

endmodule

`default_nettype wire

// ===== rtl/srp_checker.sv =====
`default_nettype none

module srp_port_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        char_ready,
  input wire logic        item_valid,
  input wire logic        item_ready,
  input wire logic        item_kind,
  input wire logic [3:0]  record_kind,
  input wire logic [31:0] address,
  input wire logic [7:0]  data_byte,
  input wire logic [7:0]  checksum_byte,
  input wire logic [1:0]  status
);

  a_reset_clears: assert property (@(posedge clk) rst |=> !item_valid && char_ready)
    else $error("output valid or input stall after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_ready |=> item_valid && $stable(item_kind) &&
      $stable(record_kind) && $stable(address) && $stable(data_byte) &&
      $stable(checksum_byte) && $stable(status))
    else $error("stalled transaction changed");

  a_write_kind: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_kind == srp_pkg::ITEM_WRITE |->
      (record_kind == srp_pkg::KIND_S1 || record_kind == srp_pkg::KIND_S2 ||
       record_kind == srp_pkg::KIND_S3) && status == srp_pkg::STATUS_OK &&
      checksum_byte == 8'd0)
    else $error("write transaction with bad type or summary fields");

  a_end_fields: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_kind == srp_pkg::ITEM_END |->
      data_byte == 8'd0 && status != 2'd3 &&
      (status == srp_pkg::STATUS_OK || checksum_byte == 8'd0 ||
       status == srp_pkg::STATUS_BAD_HEX))
    else $error("record end transaction fields inconsistent");

endmodule

bind srecord_line_parser srp_port_checker u_srp_checker (
  .clk           (clk),
  .rst           (rst),
  .char_ready    (chars.ready),
  .item_valid    (items.valid),
  .item_ready    (items.ready),
  .item_kind     (items.item_kind),
  .record_kind   (items.record_kind),
  .address       (items.address),
  .data_byte     (items.data_byte),
  .checksum_byte (items.checksum_byte),
  .status        (items.status)
);

`default_nettype wire

// ===== verif/srp_checker.sv =====
module srp_checker
  import srp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       char_valid,
  input  logic       char_ready,
  input  logic [7:0] char_code,
  input  logic       item_valid,
  input  logic       item_ready,
  input  item_t      item_seen,
  output int         mismatches,
  output int         outstanding,
  output int         checked
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_TYPE,
    PH_COUNT,
    PH_ADDR,
    PH_DATA,
    PH_CSUM,
    PH_DONE
  } parse_phase_t;

  parse_phase_t phase;
  logic [3:0]   kind_reg;
  logic [7:0]   bytes_rem;
  logic [31:0]  addr_acc;
  logic [31:0]  addr_start;
  logic [3:0]   hi_nib;
  logic         nib_half;
  logic         err_seen;
  logic [2:0]   addr_rem;
  logic [7:0]   csum_hold;

  item_t expected_items[$];
  int    miss_n = 0;
  int    match_n = 0;

  function automatic logic [2:0] addr_field_len(input logic [3:0] kind);
    case (kind)
      KIND_S2, KIND_S6, KIND_S8: return 3'd3;
      KIND_S3, KIND_S7:          return 3'd4;
      default:                   return 3'd2;
    endcase
  endfunction

  // {valid, nibble}
  function automatic logic [4:0] decode_hex(input logic [7:0] c);
    logic [7:0] d;
    if (c >= CHAR_0 && c <= CHAR_9) begin
      d = c - CHAR_0;
    end else if (c >= CHAR_UA && c <= CHAR_UF) begin
      d = c - CHAR_UA + 8'd10;
    end else if (c >= CHAR_LA && c <= CHAR_LF_HEX) begin
      d = c - CHAR_LA + 8'd10;
    end else begin
      return 5'b0;
    end
    return {1'b1, d[3:0]};
  endfunction

  task automatic clear_line();
    phase      = PH_IDLE;
    kind_reg   = 4'd0;
    bytes_rem  = 8'd0;
    addr_acc   = 32'd0;
    addr_start = 32'd0;
    hi_nib     = 4'd0;
    nib_half   = 1'b0;
    err_seen   = 1'b0;
    addr_rem   = 3'd0;
    csum_hold  = 8'd0;
  endtask

  task automatic predict_char(input logic [7:0] c);
    logic [4:0] hx;
    logic [7:0] b;
    item_t      e;
    if (c == CHAR_CR) return;
    if (c == CHAR_LF) begin
      if (phase != PH_IDLE) begin
        e               = '0;
        e.item_kind     = ITEM_END;
        e.record_kind   = (phase == PH_TYPE) ? KIND_UNKNOWN : kind_reg;
        e.address       = addr_start;
        e.checksum_byte = (phase == PH_DONE) ? csum_hold : 8'd0;
        if (err_seen) begin
          e.status = STATUS_BAD_HEX;
        end else if (phase != PH_DONE) begin
          e.status = STATUS_SHORT;
        end else begin
          e.status = STATUS_OK;
        end
        expected_items.push_back(e);
      end
      clear_line();
      return;
    end
    case (phase)
      PH_IDLE: begin
        kind_reg = (c == CHAR_S) ? KIND_S0 : KIND_UNKNOWN;
        phase    = PH_TYPE;
      end
      PH_TYPE: begin
        b = c - CHAR_0;
        if (kind_reg != KIND_UNKNOWN && c >= CHAR_0 && c <= CHAR_9) begin
          kind_reg = b[3:0];
        end else begin
          kind_reg = KIND_UNKNOWN;
        end
        phase    = PH_COUNT;
        nib_half = 1'b0;
      end
      PH_DONE: ;
      default: begin
        hx = decode_hex(c);
        if (!hx[4]) err_seen = 1'b1;
        if (!nib_half) begin
          hi_nib   = hx[3:0];
          nib_half = 1'b1;
        end else begin
          nib_half = 1'b0;
          b        = {hi_nib, hx[3:0]};
          case (phase)
            PH_COUNT: begin
              bytes_rem = b;
              addr_rem  = addr_field_len(kind_reg);
              addr_acc  = 32'd0;
              phase     = PH_ADDR;
            end
            PH_ADDR: begin
              addr_acc = {addr_acc[23:0], b};
              if (bytes_rem != 8'd0) bytes_rem--;
              if (addr_rem != 3'd0) addr_rem--;
              if (addr_rem == 3'd0) begin
                addr_start = addr_acc;
                phase      = (bytes_rem > 8'd1) ? PH_DATA : PH_CSUM;
              end
            end
            PH_DATA: begin
              if (kind_reg >= KIND_S1 && kind_reg <= KIND_S3) begin
                e             = '0;
                e.item_kind   = ITEM_WRITE;
                e.record_kind = kind_reg;
                e.address     = addr_acc;
                e.data_byte   = b;
                e.status      = STATUS_OK;
                expected_items.push_back(e);
              end
              addr_acc = addr_acc + 32'd1;
              if (bytes_rem != 8'd0) bytes_rem--;
              if (bytes_rem <= 8'd1) phase = PH_CSUM;
            end
            default: begin
              csum_hold = b;
              phase     = PH_DONE;
            end
          endcase
        end
      end
    endcase
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (miss_n < 30) begin
      $display("item %0d: %s got %0h want %0h", match_n, what, got, want);
    end
    miss_n++;
  endtask

  task automatic compare_item(input item_t got);
    item_t want;
    if (expected_items.size() == 0) begin
      report_mismatch("unexpected item, address", got.address, 32'd0);
      return;
    end
    want = expected_items.pop_front();
    match_n++;
    if (got.item_kind !== want.item_kind) begin
      report_mismatch("item_kind", 32'(got.item_kind), 32'(want.item_kind));
    end
    if (got.record_kind !== want.record_kind) begin
      report_mismatch("record_kind", 32'(got.record_kind), 32'(want.record_kind));
    end
    if (got.address !== want.address) begin
      report_mismatch("address", got.address, want.address);
    end
    if (got.data_byte !== want.data_byte) begin
      report_mismatch("data_byte", 32'(got.data_byte), 32'(want.data_byte));
    end
    if (got.checksum_byte !== want.checksum_byte) begin
      report_mismatch("checksum_byte", 32'(got.checksum_byte), 32'(want.checksum_byte));
    end
    if (got.status !== want.status) begin
      report_mismatch("status", 32'(got.status), 32'(want.status));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_line();
      expected_items.delete();
    end else begin
      if (item_valid && item_ready) compare_item(item_seen);
      if (char_valid && char_ready) predict_char(char_code);
    end
    mismatches  <= miss_n;
    outstanding <= expected_items.size();
    checked     <= match_n;
  end

endmodule

// ===== verif/tb_srecord_line_parser.sv =====
module tb_srecord_line_parser;
  import srp_pkg::*;

  localparam int RANDOM_CHARS = 780;
  localparam int HOLD_AT      = 800;
  localparam int HOLD_CYCLES  = 300;
  localparam int STALL_LIMIT  = 3000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  always #6 clk = ~clk;

  srp_char_if chars_bus ();
  srp_item_if items_bus ();

  item_t seen_item;
  int    mismatches;
  int    outstanding;
  int    checked;

  int         sent_chars = 0;
  int         sent_lines = 0;
  int         faulty_lines = 0;
  bit         calm = 1'b0;
  bit         hold_done = 1'b0;
  logic [7:0] line_buf[$];

  assign seen_item = {items_bus.item_kind, items_bus.record_kind, items_bus.address,
                      items_bus.data_byte, items_bus.checksum_byte, items_bus.status};

  srecord_line_parser i_dut (
    .clk   (clk),
    .rst   (rst),
    .chars (chars_bus),
    .items (items_bus)
  );

  srp_checker i_check (
    .clk         (clk),
    .rst         (rst),
    .char_valid  (chars_bus.valid),
    .char_ready  (chars_bus.ready),
    .char_code   (chars_bus.char_code),
    .item_valid  (items_bus.valid),
    .item_ready  (items_bus.ready),
    .item_seen   (seen_item),
    .mismatches  (mismatches),
    .outstanding (outstanding),
    .checked     (checked)
  );

  function automatic int idle_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int addr_width_for(input int digit);
    case (digit)
      2, 6, 8: return 3;
      3, 7:    return 4;
      default: return 2;
    endcase
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return CHAR_0 + 8'(n);
    return (($urandom_range(0, 1) == 0) ? CHAR_UA : CHAR_LA) + 8'(n) - 8'd10;
  endfunction

  function automatic logic [7:0] non_hex_char();
    case ($urandom_range(0, 2))
      0:       return 8'($urandom_range(8'h80, 8'hFF));
      1:       return 8'($urandom_range(8'h47, 8'h60));
      default: return 8'($urandom_range(8'h67, 8'h7E));
    endcase
  endfunction

  function automatic logic [7:0] noise_char();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    return (b == CHAR_LF) ? 8'h0B : b;
  endfunction

  task automatic push_hex_byte(input logic [7:0] b);
    line_buf.push_back(hex_char(b[7:4]));
    line_buf.push_back(hex_char(b[3:0]));
  endtask

  task automatic emit_record(input int digit, input logic [31:0] addr, input int n_data,
                             input int count_adj);
    int         cnt;
    int         alen;
    logic [31:0] sh;
    alen = addr_width_for(digit);
    cnt  = alen + n_data + 1 + count_adj;
    if (cnt < 0) cnt = 0;
    if (cnt > 255) cnt = 255;
    line_buf.push_back(CHAR_S);
    line_buf.push_back(CHAR_0 + 8'(digit));
    push_hex_byte(8'(cnt));
    for (int i = alen - 1; i >= 0; i--) begin
      sh = addr >> (8 * i);
      push_hex_byte(sh[7:0]);
    end
    repeat (n_data) push_hex_byte(8'($urandom_range(0, 255)));
    push_hex_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic send_char(input logic [7:0] c);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      chars_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    chars_bus.valid     <= 1'b1;
    chars_bus.char_code <= c;
    @(posedge clk);
    while (!chars_bus.ready) @(posedge clk);
    sent_chars++;
  endtask

  task automatic flush_line(input bit with_cr);
    if (with_cr) line_buf.push_back(CHAR_CR);
    line_buf.push_back(CHAR_LF);
    while (line_buf.size() > 0) send_char(line_buf.pop_front());
    sent_lines++;
    calm = ($urandom_range(0, 9) < 2);
  endtask

  task automatic random_line();
    int          r;
    int          digit;
    int          n_data;
    int          alen;
    logic [31:0] addr;
    r = $urandom_range(0, 99);
    if ($urandom_range(0, 4) < 3) begin
      digit = $urandom_range(1, 3);
    end else begin
      digit = $urandom_range(0, 9);
    end
    alen = addr_width_for(digit);
    case ($urandom_range(0, 99)) inside
      [0:79]:  n_data = $urandom_range(0, 5);
      [80:96]: n_data = $urandom_range(6, 24);
      default: n_data = $urandom_range(25, 254 - alen);
    endcase
    case ($urandom_range(0, 19))
      0:       addr = 32'hFFFF_FFFF - 32'($urandom_range(0, 6));
      1:       addr = 32'hFFFF - 32'($urandom_range(0, 6));
      2:       addr = 32'd0;
      default: addr = $urandom;
    endcase
    if (r >= 75) faulty_lines++;
    if (r < 75) begin
      emit_record(digit, addr, n_data, 0);
    end else if (r < 80) begin
      emit_record(digit, addr, n_data, 0);
      line_buf[$urandom_range(2, line_buf.size() - 1)] = non_hex_char();
    end else if (r < 85) begin
      emit_record(digit, addr, n_data, 0);
      repeat ($urandom_range(1, line_buf.size() - 1)) void'(line_buf.pop_back());
    end else if (r < 88) begin
      emit_record(digit, addr, n_data, -$urandom_range(1, alen + n_data + 1));
    end else if (r < 90) begin
      emit_record(digit, addr, n_data, 0);
      if ($urandom_range(0, 1) == 0) begin
        line_buf[0] = noise_char();
      end else begin
        line_buf[1] = non_hex_char();
      end
    end else if (r < 93) begin
      emit_record(digit, addr, n_data, 0);
      repeat ($urandom_range(1, 4)) line_buf.push_back(noise_char());
    end else if (r < 96) begin
      if ($urandom_range(0, 1) == 0) line_buf.push_back(CHAR_CR);
    end else begin
      repeat ($urandom_range(1, 30)) line_buf.push_back(noise_char());
    end
    if (line_buf.size() > 1 && $urandom_range(0, 19) == 0) begin
      line_buf.insert($urandom_range(0, line_buf.size() - 1), CHAR_CR);
    end
    flush_line($urandom_range(0, 9) == 0);
  endtask

  // receiver: random stalls, one long hold-off to back the block up
  initial begin
    int n;
    items_bus.ready = 1'b0;
    wait (!rst);
    @(posedge clk);
    forever begin
      if (!hold_done && sent_chars >= HOLD_AT) begin
        hold_done = 1'b1;
        items_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      n = idle_len();
      if (n > 0) begin
        items_bus.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      items_bus.ready <= 1'b1;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  end

  initial begin
    int idle;
    idle = 0;
    while (idle < STALL_LIMIT) begin
      @(posedge clk);
      if ((chars_bus.valid && chars_bus.ready) || (items_bus.valid && items_bus.ready)) begin
        idle = 0;
      end else begin
        idle++;
      end
    end
    $display("watchdog: no transaction for %0d cycles, %0d results pending",
             STALL_LIMIT, outstanding);
    $display("srecord_line_parser: mismatch");
    $finish;
  end

  initial begin
    int stop_at;
    chars_bus.valid     = 1'b0;
    chars_bus.char_code = 8'h00;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // minimal S1, then data extremes by hand
    emit_record(1, 32'h0000, 0, 0);
    flush_line(1'b0);
    line_buf = '{CHAR_S, CHAR_0 + 8'd1};
    push_hex_byte(8'h05);
    push_hex_byte(8'hFF);
    push_hex_byte(8'hFF);
    push_hex_byte(8'h00);
    push_hex_byte(8'hFF);
    push_hex_byte(8'h00);
    flush_line(1'b0);
    emit_record(2, 32'h00AB_CDEF, 4, 0);
    flush_line(1'b0);
    emit_record(3, 32'hFFFF_FFFE, 4, 0);
    flush_line(1'b1);
    emit_record(0, 32'h0000, 5, 0);
    flush_line(1'b0);
    for (int d = 4; d <= 9; d++) begin
      emit_record(d, $urandom, 2, 0);
      flush_line(1'b0);
    end
    // blank line, then carriage return inside a record
    flush_line(1'b0);
    emit_record(1, 32'h1234, 2, 0);
    line_buf.insert(5, CHAR_CR);
    flush_line(1'b1);
    // bad hex digit in the data
    emit_record(1, 32'h4000, 3, 0);
    line_buf[9] = 8'h47;
    flush_line(1'b0);
    // line ended early at each field
    line_buf.push_back(CHAR_S);
    flush_line(1'b0);
    line_buf = '{CHAR_S, CHAR_0 + 8'd1, CHAR_0};
    flush_line(1'b0);
    emit_record(3, 32'h8765_4321, 2, 0);
    repeat (12) void'(line_buf.pop_back());
    flush_line(1'b0);
    emit_record(2, 32'h0010_0000, 4, 0);
    repeat (5) void'(line_buf.pop_back());
    flush_line(1'b0);
    emit_record(1, 32'h2000, 1, 0);
    void'(line_buf.pop_back());
    flush_line(1'b0);
    // first character not S, then type digit not a digit
    emit_record(1, 32'h3000, 2, 0);
    line_buf[0] = 8'h58;
    flush_line(1'b0);
    emit_record(1, 32'h3000, 2, 0);
    line_buf[1] = 8'h5A;
    flush_line(1'b0);
    // count too small
    emit_record(1, 32'h5000, 3, -6);
    flush_line(1'b0);
    emit_record(3, 32'h0102_0304, 3, -6);
    flush_line(1'b0);
    // trailing characters after the checksum
    emit_record(1, 32'h6000, 1, 0);
    line_buf.push_back(8'h2A);
    line_buf.push_back(8'h39);
    flush_line(1'b0);
    // bad hex and early end together
    emit_record(2, 32'h0070_0000, 3, 0);
    line_buf[5] = 8'hFF;
    repeat (4) void'(line_buf.pop_back());
    flush_line(1'b0);
    line_buf = '{8'h00, 8'hFF, 8'h80, 8'h7F};
    flush_line(1'b0);

    stop_at = sent_chars + RANDOM_CHARS;
    while (sent_chars < stop_at) random_line();
    chars_bus.valid <= 1'b0;

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (12) @(posedge clk);

    $display("sent %0d lines (%0d with faults), %0d characters; checked %0d result items",
             sent_lines, faulty_lines, sent_chars, checked);
    $display("output held off once for %0d cycles with input still offered", HOLD_CYCLES);
    if (mismatches == 0 && outstanding == 0) begin
      $display("srecord_line_parser: match");
    end else begin
      $display("srecord_line_parser: mismatch");
    end
    $finish;
  end

endmodule

// ===== srecord_line_parser.f =====
rtl/srp_pkg.sv
rtl/srp_char_if.sv
rtl/srp_item_if.sv
rtl/srp_parse_core.sv
rtl/srp_out_buffer.sv
rtl/srecord_line_parser.sv
rtl/srp_checker.sv
verif/srp_checker.sv
verif/tb_srecord_line_parser.sv
